>>> rtl/osrc_pkg.sv
// ----------------------------------------------------------------------------
// osrc_pkg
// types and constants for the operand stack with a four-word register cache
// ----------------------------------------------------------------------------
package osrc_pkg;

  localparam int WORD_W     = 32;
  localparam int DEPTH_W    = 9;
  localparam int COUNT_W    = 3;
  localparam int TOP_W      = 2;
  localparam int SPILLOUT_W = 9;
  localparam int RING_N     = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 176;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_PEEK  = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_OVERFLOW  = 2'd1,
    FAULT_UNDERFLOW = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FILL_RD,
    ST_FILL_WR,
    ST_DEEP_WR,
    ST_SPILL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/operand_stack_register_cache.sv
// ----------------------------------------------------------------------------
// operand_stack_register_cache
// 32-bit operand stack, top four words in a register ring, rest in spill memory
// ----------------------------------------------------------------------------
// steps per request when the ring already holds what it needs: execute, then
// result, which waits while the output is held; a push onto a full ring spills in the execute step
// a fill from spill memory adds a memory read and a ring write per word, then
// execute runs again; a peek below the ring adds a memory word step, a flush a spill step per word
// one request at a time; the next request can be taken as the result goes to the output register
// rst clears the ring, counts and control; spill memory is not cleared
module operand_stack_register_cache
  import osrc_pkg::*;
#(
  parameter int SPILL_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // push_value, peek_depth, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_value, held_count, top_register, spilled_count,
  // ring_word0, ring_word1, ring_word2, ring_word3, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fault
  output logic [1:0]            m_axis_tuser
);

  localparam int AW = $clog2(SPILL_DEPTH);
  localparam int CW = $clog2(SPILL_DEPTH + 1);
  localparam int TW = (CW + 1 > DEPTH_W) ? CW + 1 : DEPTH_W;

  state_t state, state_next;

  cmd_t                cmd;
  logic [WORD_W-1:0]   value;
  logic [DEPTH_W-1:0]  depth;

  logic [WORD_W-1:0]   ring [RING_N];
  logic [WORD_W-1:0]   ring_next [RING_N];
  logic [COUNT_W-1:0]  ring_count, ring_count_next;
  logic [TOP_W-1:0]    ring_top, ring_top_next;
  logic [CW-1:0]       spill_count, spill_count_next;
  logic [WORD_W-1:0]   rd_value, rd_value_next;
  fault_t              fault, fault_next;

  logic [WORD_W-1:0]   spill_mem [SPILL_DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [WORD_W-1:0]   mem_q;

  logic                accept;
  logic                out_free;
  logic [CW:0]         total;
  logic [TW-1:0]       deep_idx;
  logic [COUNT_W-1:0]  fill_want;
  logic [CW+SPILLOUT_W-1:0] spill_ext;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) || (state == ST_DONE && out_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign total         = (CW + 1)'(ring_count) + (CW + 1)'(spill_count);
  assign deep_idx      = TW'(spill_count) + TW'(ring_count) - TW'(depth) - TW'(1);
  assign fill_want     = (cmd == CMD_POP) ? COUNT_W'(1) : COUNT_W'(depth[1:0]) + COUNT_W'(1);
  assign spill_ext     = (CW + SPILLOUT_W)'(spill_count);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        case (cmd)
          CMD_POP: begin
            if (ring_count == '0 && spill_count != '0) state_next = ST_FILL_RD;
          end
          CMD_PEEK: begin
            if (TW'(depth) < TW'(total)) begin
              if (depth[DEPTH_W-1:2] != '0) begin
                state_next = ST_DEEP_WR;
              end else if (ring_count <= COUNT_W'(depth[1:0])) begin
                state_next = ST_FILL_RD;
              end
            end
          end
          CMD_FLUSH: begin
            if (total <= (CW + 1)'(SPILL_DEPTH) && ring_count != '0) state_next = ST_SPILL;
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_FILL_RD: state_next = ST_FILL_WR;
      ST_FILL_WR: begin
        state_next = (ring_count + COUNT_W'(1) < fill_want) ? ST_FILL_RD : ST_EXEC;
      end
      ST_DEEP_WR: state_next = ST_DONE;
      ST_SPILL: begin
        if (ring_count == COUNT_W'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    ring_next        = ring;
    ring_count_next  = ring_count;
    ring_top_next    = ring_top;
    spill_count_next = spill_count;
    rd_value_next    = rd_value;
    fault_next       = fault;
    mem_we           = 1'b0;
    mem_waddr        = spill_count[AW-1:0];
    mem_wdata        = ring[ring_top - TOP_W'(3)];
    mem_raddr        = AW'(spill_count - CW'(1));

    if (accept) begin
      rd_value_next = '0;
      fault_next    = FAULT_NONE;
    end

    case (state)
      ST_EXEC: begin
        case (cmd)
          CMD_PUSH: begin
            if (ring_count == COUNT_W'(RING_N) && spill_count >= CW'(SPILL_DEPTH)) begin
              fault_next = FAULT_OVERFLOW;
            end else begin
              if (ring_count == COUNT_W'(RING_N)) begin
                mem_we           = 1'b1;
                spill_count_next = spill_count + CW'(1);
              end else begin
                ring_count_next  = ring_count + COUNT_W'(1);
              end
              ring_top_next = (ring_count == '0) ? '0 : ring_top + TOP_W'(1);
              ring_next[(ring_count == '0) ? TOP_W'(0) : ring_top + TOP_W'(1)] = value;
            end
          end
          CMD_POP: begin
            if (ring_count == '0 && spill_count == '0) begin
              fault_next = FAULT_UNDERFLOW;
            end else if (ring_count != '0) begin
              rd_value_next   = ring[ring_top];
              ring_count_next = ring_count - COUNT_W'(1);
              ring_top_next   = (ring_count == COUNT_W'(1)) ? '0 : ring_top - TOP_W'(1);
            end
          end
          CMD_PEEK: begin
            if (TW'(depth) >= TW'(total)) begin
              fault_next = FAULT_UNDERFLOW;
            end else if (depth[DEPTH_W-1:2] != '0) begin
              mem_raddr = deep_idx[AW-1:0];
            end else if (ring_count > COUNT_W'(depth[1:0])) begin
              rd_value_next = ring[ring_top - depth[1:0]];
            end else if (ring_count == '0) begin
              ring_top_next = depth[1:0];
            end
          end
          CMD_FLUSH: begin
            if (total > (CW + 1)'(SPILL_DEPTH)) fault_next = FAULT_OVERFLOW;
          end
          default: fault_next = fault;
        endcase
      end
      ST_FILL_WR: begin
        ring_next[ring_top - ring_count[TOP_W-1:0]] = mem_q;
        ring_count_next  = ring_count + COUNT_W'(1);
        spill_count_next = spill_count - CW'(1);
      end
      ST_DEEP_WR: begin
        rd_value_next = mem_q;
      end
      ST_SPILL: begin
        mem_we           = 1'b1;
        mem_wdata        = ring[ring_top - TOP_W'(ring_count - COUNT_W'(1))];
        ring_count_next  = ring_count - COUNT_W'(1);
        spill_count_next = spill_count + CW'(1);
        if (ring_count == COUNT_W'(1)) ring_top_next = '0;
      end
      default: ring_top_next = ring_top_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) spill_mem[mem_waddr] <= mem_wdata;
    mem_q <= spill_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ring_count    <= '0;
      ring_top      <= '0;
      spill_count   <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < RING_N; i++) ring[i] <= '0;
    end else begin
      state       <= state_next;
      ring        <= ring_next;
      ring_count  <= ring_count_next;
      ring_top    <= ring_top_next;
      spill_count <= spill_count_next;
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_value <= rd_value_next;
    fault    <= fault_next;
    if (accept) begin
      cmd   <= cmd_t'(s_axis_tuser);
      value <= s_axis_tdata[WORD_W-1:0];
      depth <= s_axis_tdata[WORD_W+DEPTH_W-1:WORD_W];
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {2'b00, ring[3], ring[2], ring[1], ring[0],
                       spill_ext[SPILLOUT_W-1:0], ring_top, ring_count, rd_value};
      m_axis_tuser <= fault;
    end
  end

  a_ring_count_range: assert property (@(posedge clk) disable iff (rst)
    ring_count <= COUNT_W'(RING_N))
    else $error("ring count above four");

  a_spill_write_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> spill_count < CW'(SPILL_DEPTH))
    else $error("spill write past memory end");

  a_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL_RD) |-> spill_count != '0)
    else $error("fill from empty spill memory");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ring_count == '0) |-> ring_top == '0)
    else $error("empty ring with nonzero top");

endmodule
